FILE: sv/hsl_pkg.sv
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared types and constants for the histogram survival lookup.
// ----------------------------------------------------------------------------
package hsl_pkg;

    localparam int unsigned ONE_Q16 = 65536;
    localparam int          MAX_BINS = 256;

    typedef enum logic [1:0] {
        K_WR_EDGE = 2'd0,
        K_WR_DENS = 2'd1,
        K_WR_SURV = 2'd2,
        K_QUERY   = 2'd3
    } t_kind;

    // Divider request: signed dividend over signed divisor, both 64-bit wide
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

endpackage

FILE: sv/hsl_div.sv
// ----------------------------------------------------------------------------
// hsl_div
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module hsl_div
    import hsl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [63:0] r_q, n_q;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_d;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] w_trial;
    logic [63:0] w_rem_sh;

    // Shift one dividend bit into the partial remainder and try a subtract
    always_comb begin
        w_rem_sh = {r_rem[62:0], r_q[63]};
        w_trial  = {1'b0, w_rem_sh} - {1'b0, r_d};
        n_q      = {r_q[62:0], ~w_trial[64]};
        n_rem    = w_trial[64] ? w_rem_sh : w_trial[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_rem  <= '0;
                r_q    <= i_req.num[63] ? -i_req.num : i_req.num;
                r_d    <= i_req.den[63] ? -i_req.den : i_req.den;
                r_neg  <= i_req.num[63] ^ i_req.den[63];
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? -r_q : r_q;

endmodule

FILE: sv/histogram_survival_lookup.sv
// ----------------------------------------------------------------------------
// histogram_survival_lookup
// Piecewise histogram lookup: bin, density, survival and cdf of a point.
// ----------------------------------------------------------------------------
// Usage:
//   Input transaction: i_kind, i_entry_index, i_entry_value, i_query_point
//   are taken when start is high and busy is low. Kinds 0..2 write the
//   edge, density or survival memory and give no result; busy stays high
//   for one cycle, and the next transaction can be taken once it drops.
//   A query gives one result marked by o_valid for one cycle. A point out
//   of range skips the bin search; a point that needs interpolation also
//   goes through the bit-serial divider. With 256 bins the search takes
//   at most 8 probes.
//   Busy drops in the cycle the result is shown, so the next transaction
//   can be taken in that cycle. The receiver cannot stall.
//   Config: bins_in_use via cfg_valid/cfg_ready, written while idle.
//   Reset clears control state only; memories are undefined until written.
// ----------------------------------------------------------------------------
module histogram_survival_lookup
    import hsl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    input  logic [1:0]  i_kind,
    input  logic [8:0]  i_entry_index,
    input  logic signed [31:0] i_entry_value,
    input  logic signed [31:0] i_query_point,
    output logic        o_valid,
    output logic signed [8:0]  o_bin_found,
    output logic [31:0] o_density_value,
    output logic [16:0] o_survival_value,
    output logic [16:0] o_cdf_value
);

    localparam int AW = $clog2(MAX_BINS + 1);
    localparam int SW = $clog2(MAX_BINS);
    localparam int BW = AW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_WRITE, S_LO, S_HI, S_CHK, S_PRB, S_CMP,
        S_RD0, S_RD1, S_RD2, S_RD3, S_CALC, S_DIV, S_OUT
    } t_state;

    logic signed [31:0] m_edge [MAX_BINS+1];
    logic [31:0] m_dens [MAX_BINS];
    logic [16:0] m_surv [MAX_BINS];

    t_state r_state;
    logic [8:0]  r_bins;
    logic [1:0]  r_kind;
    logic [8:0]  r_idx;
    logic signed [31:0] r_val, r_x;
    logic signed [BW-1:0] r_b, r_e, r_p;
    logic [AW-1:0] w_n;
    logic [AW-1:0] r_ea;
    logic [SW-1:0] r_sa;
    logic signed [31:0] r_eq;
    logic [31:0] r_dq;
    logic [16:0] r_sq;
    logic signed [31:0] r_lo_edge, r_e_bin, r_e_prev;
    logic [16:0] r_s_bin, r_s_prev;
    logic [31:0] r_dens;
    logic signed [8:0] r_bin;
    t_div_req    r_dreq;
    t_div_rsp    w_drsp;
    logic signed [17:0] r_slo;
    logic        r_valid;
    logic signed [8:0]  r_o_bin;
    logic [31:0] r_o_dens;
    logic [16:0] r_o_surv;
    logic signed [63:0] w_sum;
    logic signed [32:0] w_dx;
    logic signed [17:0] w_ds;
    logic signed [50:0] w_prod;

    // Midpoint of lo..hi with the halving truncated toward zero
    function automatic logic signed [BW-1:0] f_mid(logic signed [BW-1:0] lo,
                                                   logic signed [BW-1:0] hi);
        logic signed [BW-1:0] d;
        d = hi - lo;
        if (d < 0) d = d + BW'(1);
        return lo + (d >>> 1);
    endfunction

    // Effective bin count, clamped to 1..MAX_BINS
    always_comb begin
        if (r_bins == 9'd0) w_n = AW'(1);
        else if ({23'd0, r_bins} > MAX_BINS) w_n = AW'(MAX_BINS);
        else w_n = AW'(r_bins);
    end

    // Interpolation product: edge offset times survival step
    assign w_dx   = 33'(r_x) - 33'(r_eq);
    assign w_ds   = $signed({1'b0, r_s_bin}) - $signed({1'b0, r_sq});
    assign w_prod = w_dx * w_ds;

    // Zero divisor gives no interpolated term
    assign w_sum = $signed({{46{r_slo[17]}}, r_slo}) +
                   ((r_dreq.den == '0) ? 64'sd0 : $signed(w_drsp.quo));

    // Memories: registered reads
    always_ff @(posedge i_clk) begin
        r_eq <= m_edge[r_ea];
        r_dq <= m_dens[r_sa];
        r_sq <= m_surv[r_sa];
        if (r_state == S_WRITE) begin
            if (r_kind == K_WR_EDGE && {23'd0, r_idx} <= MAX_BINS)
                m_edge[AW'(r_idx)] <= r_val;
            if (r_kind == K_WR_DENS && {23'd0, r_idx} < MAX_BINS)
                m_dens[SW'(r_idx)] <= r_val;
            if (r_kind == K_WR_SURV && {23'd0, r_idx} < MAX_BINS)
                m_surv[SW'(r_idx)] <= r_val[16:0];
        end
    end

    hsl_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_dreq),
        .o_rsp  (w_drsp)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bins  <= 9'd1;
            r_valid <= 1'b0;
            r_dreq.start <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_dreq.start <= 1'b0;
            if (cfg_valid && cfg_ready) r_bins <= cfg_data;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_kind <= i_kind;
                        r_idx  <= i_entry_index;
                        r_val  <= i_entry_value;
                        r_x    <= i_query_point;
                        r_ea   <= '0;
                        r_state <= (i_kind == K_QUERY) ? S_LO : S_WRITE;
                    end
                end
                S_WRITE: r_state <= S_IDLE;
                S_LO: begin
                    r_ea <= w_n;
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_lo_edge <= r_eq;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_x < r_lo_edge || r_x >= r_eq) begin
                        r_bin   <= -9'sd1;
                        r_dens  <= '0;
                        r_o_surv <= (r_x < r_lo_edge) ? 17'(ONE_Q16) : 17'd0;
                        r_state <= S_OUT;
                    end else begin
                        r_b <= '0;
                        r_e <= BW'(w_n) - BW'(1);
                        r_p <= (BW'(w_n) - BW'(1)) >>> 1;
                        r_ea <= AW'((BW'(w_n) - BW'(1)) >>> 1);
                        r_state <= S_PRB;
                    end
                end
                S_PRB: begin
                    if (r_b < r_e) r_state <= S_CMP;
                    else r_state <= S_RD0;
                end
                S_CMP: begin
                    if (r_eq == r_x) begin
                        r_state <= S_RD0;
                    end else if (r_eq > r_x) begin
                        r_e <= r_p - BW'(1);
                        r_p <= f_mid(r_b, r_p - BW'(1));
                        r_ea <= AW'(f_mid(r_b, r_p - BW'(1)));
                        r_state <= S_PRB;
                    end else begin
                        r_b <= r_p + BW'(1);
                        r_p <= f_mid(r_p + BW'(1), r_e);
                        r_ea <= AW'(f_mid(r_p + BW'(1), r_e));
                        r_state <= S_PRB;
                    end
                end
                S_RD0: begin
                    // clamp p into 0..n-1
                    if (r_p < 0) r_p <= '0;
                    else if (r_p > BW'(w_n) - BW'(1)) r_p <= BW'(w_n) - BW'(1);
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_ea <= AW'(r_p);
                    r_sa <= SW'(r_p);
                    r_bin <= 9'(r_p);
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_ea <= (r_p == 0) ? '0 : AW'(r_p - BW'(1));
                    r_sa <= (r_p == 0) ? '0 : SW'(r_p - BW'(1));
                    r_state <= S_RD3;
                end
                S_RD3: begin
                    r_e_bin <= r_eq;
                    r_dens  <= r_dq;
                    r_s_bin <= r_sq;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_e_prev <= r_eq;
                    r_s_prev <= r_sq;
                    if (r_x < r_e_bin && r_p != 0) begin
                        r_slo <= $signed({1'b0, r_sq});
                        r_dreq.start <= 1'b1;
                        r_dreq.num <= 64'(w_prod);
                        r_dreq.den <= 64'(r_e_bin) - 64'(r_eq);
                        r_state <= S_DIV;
                    end else begin
                        r_o_surv <= (r_s_bin > 17'(ONE_Q16)) ? 17'(ONE_Q16) : r_s_bin;
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        if (w_sum < 0) r_o_surv <= '0;
                        else if (w_sum > 64'(ONE_Q16)) r_o_surv <= 17'(ONE_Q16);
                        else r_o_surv <= w_sum[16:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_valid  <= 1'b1;
                    r_o_bin  <= r_bin;
                    r_o_dens <= r_dens;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);
    assign cfg_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;
    assign o_bin_found = r_o_bin;
    assign o_density_value = r_o_dens;
    assign o_survival_value = r_o_surv;
    assign o_cdf_value = 17'(ONE_Q16) - r_o_surv;

endmodule

FILE: sv/hsl_checker.sv
// ----------------------------------------------------------------------------
// hsl_checker
// Port-level checks on the histogram survival lookup.
// ----------------------------------------------------------------------------
module hsl_checker
    import hsl_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_kind,
    input logic        o_valid,
    input logic signed [8:0] o_bin_found,
    input logic [31:0] o_density_value,
    input logic [16:0] o_survival_value,
    input logic [16:0] o_cdf_value
);

    // survival plus cdf is one
    a_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_survival_value + o_cdf_value == 17'(ONE_Q16)))
        else $error("survival plus cdf mismatch");

    // out of range gives zero density
    a_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bin_found == -9'sd1 |-> o_density_value == 32'd0)
        else $error("density nonzero out of range");

    // survival saturated
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_survival_value <= 17'(ONE_Q16))
        else $error("survival above one");

    // a write never produces a result next cycle
    a_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_kind != K_QUERY |=> !o_valid)
        else $error("result after write");

endmodule

bind histogram_survival_lookup hsl_checker u_hsl_checker (.*);

FILE: dv/histogram_survival_lookup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_survival_lookup_tb
// Loads edge, density and survival tables and checks every query result
// against a cycle-free predictor of the bin search, interpolation and
// saturation, over several bin counts and idle patterns.
// ----------------------------------------------------------------------------
module histogram_survival_lookup_tb;
    import hsl_pkg::*;

    localparam int NBINS   = 256;
    localparam int DRAIN   = 200;
    localparam int N_RAND  = 700;

    typedef struct packed {
        logic signed [8:0] bin;
        logic [31:0]       dens;
        logic [16:0]       surv;
        logic [16:0]       cdf;
    } lookup_result_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [8:0]        cfg_data = '0;
    logic [1:0]        i_kind = '0;
    logic [8:0]        i_entry_index = '0;
    logic signed [31:0] i_entry_value = '0;
    logic signed [31:0] i_query_point = '0;
    logic              o_valid;
    logic signed [8:0] o_bin_found;
    logic [31:0]       o_density_value;
    logic [16:0]       o_survival_value;
    logic [16:0]       o_cdf_value;

    // Shadow copy of the block's tables and register
    logic signed [31:0] edge_mem [0:NBINS];
    logic [31:0]        dens_mem [0:NBINS-1];
    logic [16:0]        surv_mem [0:NBINS-1];
    logic [8:0]         bins_reg = 9'd1;

    lookup_result_t pending_results[$];
    int             mismatch_count = 0;
    int             sender_idle_pct = 0;

    histogram_survival_lookup DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .i_kind           (i_kind),
        .i_entry_index    (i_entry_index),
        .i_entry_value    (i_entry_value),
        .i_query_point    (i_query_point),
        .o_valid          (o_valid),
        .o_bin_found      (o_bin_found),
        .o_density_value  (o_density_value),
        .o_survival_value (o_survival_value),
        .o_cdf_value      (o_cdf_value)
    );

    always #1 i_clk = ~i_clk;

    // Limit the run
    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int active_bins();
        if (bins_reg == 0) return 1;
        if (bins_reg > NBINS) return NBINS;
        return int'(bins_reg);
    endfunction

    // Predict bin, density, survival and cdf of one query point
    function automatic lookup_result_t evaluate_query(logic signed [31:0] x);
        lookup_result_t r;
        int     n, lo_i, hi_i, p, bin;
        bit     hit;
        longint surv, s_lo, s_hi, dx, den, term;
        n = active_bins();
        lo_i = 0;
        hi_i = n - 1;
        p = lo_i + (hi_i - lo_i) / 2;
        hit = 0;
        if (x < edge_mem[0] || x >= edge_mem[n]) begin
            bin = -1;
        end else begin
            while (lo_i < hi_i && !hit) begin
                if (p < 0 || p > n - 1) break;
                if (edge_mem[p] == x) hit = 1;
                else begin
                    if (edge_mem[p] > x) hi_i = p - 1;
                    else lo_i = p + 1;
                    p = lo_i + (hi_i - lo_i) / 2;
                end
            end
            if (p < 0) p = 0;
            if (p > n - 1) p = n - 1;
            bin = p;
        end
        if (bin < 0) begin
            r.dens = '0;
            surv = (x < edge_mem[0]) ? ONE_Q16 : 0;
        end else begin
            r.dens = dens_mem[bin];
            if (x < edge_mem[bin] && bin >= 1) begin
                s_lo = surv_mem[bin-1];
                s_hi = surv_mem[bin];
                dx = longint'(x) - longint'(edge_mem[bin-1]);
                den = longint'(edge_mem[bin]) - longint'(edge_mem[bin-1]);
                term = (den != 0) ? (dx * (s_hi - s_lo)) / den : 0;
                surv = s_lo + term;
            end else begin
                surv = surv_mem[bin];
            end
            if (surv < 0) surv = 0;
            if (surv > ONE_Q16) surv = ONE_Q16;
        end
        r.bin  = bin[8:0];
        r.surv = surv[16:0];
        r.cdf  = 17'(longint'(ONE_Q16) - surv);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %0s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        lookup_result_t want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_bin_found, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_bin_found !== want.bin)
                    report_mismatch("bin_found", o_bin_found, want.bin);
                if (o_density_value !== want.dens)
                    report_mismatch("density_value", o_density_value, want.dens);
                if (o_survival_value !== want.surv)
                    report_mismatch("survival_value", o_survival_value, want.surv);
                if (o_cdf_value !== want.cdf)
                    report_mismatch("cdf_value", o_cdf_value, want.cdf);
            end
        end
    end

    // Send one transaction; called and returning at a falling edge
    task automatic send_item(t_kind k, logic [8:0] idx, logic signed [31:0] val,
                             logic signed [31:0] pt);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_kind        <= k;
        i_entry_index <= idx;
        i_entry_value <= val;
        i_query_point <= pt;
        while (busy) @(negedge i_clk);
        // Accepted at the coming rising edge: advance the shadow state
        case (k)
            K_WR_EDGE: if (idx <= NBINS) edge_mem[idx] = val;
            K_WR_DENS: if (idx < NBINS) dens_mem[idx] = val;
            K_WR_SURV: if (idx < NBINS) surv_mem[idx] = val[16:0];
            K_QUERY:   pending_results.push_back(evaluate_query(pt));
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    // Write the bin count in exactly one transaction
    task automatic write_bins(logic [8:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        bins_reg = value;
        @(negedge i_clk);
    endtask

    task automatic query(logic signed [31:0] pt);
        send_item(K_QUERY, 9'($urandom), $urandom, pt);
    endtask

    // Fill all three tables: sorted edges spanning the full range
    task automatic load_tables();
        int vals[$];
        for (int i = 0; i < NBINS - 1; i++) vals.push_back(int'($urandom));
        vals.sort();
        for (int i = 1; i < vals.size(); i++)
            if ($urandom_range(15) == 0) vals[i] = vals[i-1];
        vals.push_front(32'sh8000_0000);
        vals.push_back(32'sh7FFF_FFFF);
        for (int i = 0; i <= NBINS; i++) send_item(K_WR_EDGE, 9'(i), vals[i], $urandom);
        for (int i = 0; i < NBINS; i++) begin
            send_item(K_WR_DENS, 9'(i), $urandom, $urandom);
            send_item(K_WR_SURV, 9'(i),
                      ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, ONE_Q16),
                      $urandom);
        end
    endtask

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return 32'(v);
    endfunction

    // Pick a point near an edge, inside a bin, or anywhere
    function automatic logic signed [31:0] pick_point();
        int     n, k;
        longint lo, span;
        n = active_bins();
        k = $urandom_range(0, n);
        case ($urandom_range(3))
            0: return clip32(longint'(edge_mem[k]) + $urandom_range(0, 6) - 3);
            1: return $urandom;
            default: begin
                if (k == n) k = n - 1;
                lo = edge_mem[k];
                span = longint'(edge_mem[k+1]) - lo;
                if (span <= 0) return edge_mem[k];
                return clip32(lo + longint'({$urandom, $urandom} % span));
            end
        endcase
    endfunction

    task automatic test_directed();
        // Ignored writes at out-of-range indexes
        send_item(K_WR_EDGE, 9'd257, 32'sh7FFF_FFFF, 0);
        send_item(K_WR_EDGE, 9'd511, 32'sh8000_0000, 0);
        send_item(K_WR_DENS, 9'd256, 32'shFFFF_FFFF, 0);
        send_item(K_WR_SURV, 9'd300, 32'sh0001_FFFF, 0);
        write_bins(9'd4);
        // Edges with an equal pair and survival above one and rising
        send_item(K_WR_EDGE, 9'd0, -32'sd100000, 0);
        send_item(K_WR_EDGE, 9'd1, -32'sd1000, 0);
        send_item(K_WR_EDGE, 9'd2, -32'sd1000, 0);
        send_item(K_WR_EDGE, 9'd3, 32'sd70000, 0);
        send_item(K_WR_EDGE, 9'd4, 32'sd900000, 0);
        send_item(K_WR_SURV, 9'd0, 32'sh0001_FFFF, 0);
        send_item(K_WR_SURV, 9'd1, 32'sd40000, 0);
        send_item(K_WR_SURV, 9'd2, 32'sd60000, 0);
        send_item(K_WR_SURV, 9'd3, 32'sd0, 0);
        query(32'sh8000_0000);
        query(-32'sd100001);
        query(-32'sd100000);
        query(-32'sd50000);
        query(-32'sd1000);
        query(32'sd0);
        query(32'sd70000);
        query(32'sd500000);
        query(32'sd900000);
        query(32'sh7FFF_FFFF);
        drain();
    endtask

    // Scrambled edges: the search still lands inside the table
    task automatic test_unsorted_edges();
        int                 idxs[12];
        logic signed [31:0] saved[12];
        write_bins(9'd256);
        for (int i = 0; i < 12; i++) begin
            idxs[i]  = $urandom_range(1, 255);
            saved[i] = edge_mem[idxs[i]];
            send_item(K_WR_EDGE, 9'(idxs[i]), $urandom, 0);
        end
        for (int i = 0; i < 20; i++) query(pick_point());
        // Put the scrambled edges back, latest first
        for (int i = 11; i >= 0; i--) send_item(K_WR_EDGE, 9'(idxs[i]), saved[i], 0);
        drain();
    endtask

    task automatic test_random(int items, int idle_pct);
        logic [8:0]         idx;
        logic signed [31:0] val;
        longint             span;
        sender_idle_pct = idle_pct;
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(99) < 15) begin
                idx = 9'($urandom);
                val = $urandom;
                // Keep most edge rewrites sorted
                if (idx >= 1 && idx < NBINS && $urandom_range(4) != 0) begin
                    span = longint'(edge_mem[idx+1]) - longint'(edge_mem[idx-1]) + 1;
                    if (span > 0)
                        val = clip32(longint'(edge_mem[idx-1])
                                     + longint'({$urandom, $urandom} % span));
                end
                send_item(t_kind'($urandom_range(0, 2)), idx, val, $urandom);
            end else begin
                query(pick_point());
            end
        end
        drain();
    endtask

    task automatic test_bin_counts(int items, int idle_pct);
        write_bins(9'd1);
        test_random(items / 6, idle_pct);
        write_bins(9'd256);
        test_random(items / 3, idle_pct);
        write_bins(9'd0);
        test_random(items / 12, idle_pct);
        write_bins(9'd511);
        test_random(items / 12, idle_pct);
        write_bins(9'($urandom_range(2, 40)));
        test_random(items / 3, idle_pct);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        load_tables();
        test_directed();
        test_unsorted_edges();
        test_bin_counts(N_RAND / 3, 17);
        test_bin_counts(N_RAND / 3, 52);
        test_bin_counts(N_RAND / 3, 0);
        drain();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
